>>> src/imuf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// imuf_pkg
// Types and constants shared by the IMU frame unpacker and gyro smoother.
// ---------------------------------------------------------------------------
package imuf_pkg;

    localparam int TAPS        = 5;   // moving average length, 1..8
    localparam int FRAME_BYTES = 14;
    localparam int HELD_BYTES  = FRAME_BYTES - 1;
    localparam int POS_W       = 4;
    localparam int HIST_D      = (TAPS > 1) ? TAPS - 1 : 1;

    // full-width sum of TAPS signed 16-bit samples
    localparam int SUM_W       = 16 + $clog2(TAPS);

    // divide by TAPS: magnitude times ceil(2^SHIFT / TAPS), exact for |sum| < 2^18
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + TAPS - 1) / TAPS);
    localparam int PROD_W      = SUM_W + RECIP_W;

    // frame queue between front and back
    localparam int FQ_DEPTH    = 2;
    localparam int FQ_PTR_W    = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int FQ_CNT_W    = $clog2(FQ_DEPTH + 1);

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] temperature_raw;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } t_frame;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] temperature_raw;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y_smoothed;
        logic signed [15:0] gyro_z_smoothed;
    } t_result;

    // handshake between a queue and its consumer
    typedef struct packed {
        logic valid;
        logic take;
    } t_q_hs;

endpackage : imuf_pkg
`default_nettype wire

>>> src/imuf_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// imuf_front
// Byte assembler: tracks the burst position, holds bytes 0..12 and emits a
// raw frame word set when byte 13 arrives.
// ---------------------------------------------------------------------------
module imuf_front
    import imuf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    output logic          o_frame_push,
    output t_frame        o_frame
);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] pos_eff;
    logic [7:0]       r_held [HELD_BYTES];
    logic             last_byte;

    assign pos_eff   = i_item.frame_start ? '0 : r_pos;
    assign last_byte = (pos_eff == POS_W'(HELD_BYTES));

    always_comb begin
        n_pos = r_pos;
        if (i_accept) begin
            n_pos = last_byte ? '0 : pos_eff + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !last_byte) begin
            r_held[pos_eff] <= i_item.raw_byte;
        end
    end

    assign o_frame_push = i_accept && last_byte;

    // big-endian words; byte 13 comes straight from the input
    assign o_frame.accel_x         = {r_held[0],  r_held[1]};
    assign o_frame.accel_y         = {r_held[2],  r_held[3]};
    assign o_frame.accel_z         = {r_held[4],  r_held[5]};
    assign o_frame.temperature_raw = {r_held[6],  r_held[7]};
    assign o_frame.gyro_x          = {r_held[8],  r_held[9]};
    assign o_frame.gyro_y          = {r_held[10], r_held[11]};
    assign o_frame.gyro_z          = {r_held[12], i_item.raw_byte};

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(HELD_BYTES))
        else $error("byte position out of range");

    a_wrap_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_push |=> r_pos == '0)
        else $error("position did not wrap after a frame");

endmodule : imuf_front
`default_nettype wire

>>> src/imuf_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// imuf_fifo
// Short frame queue that decouples the byte assembler from the filter.
// ---------------------------------------------------------------------------
module imuf_fifo
    import imuf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_frame i_frame,
    output logic        o_full,
    input  wire t_q_hs  i_hs_take,
    output t_q_hs       o_hs,
    output t_frame      o_frame
);

    t_frame                r_mem [FQ_DEPTH];
    logic [FQ_PTR_W-1:0]   r_wp;
    logic [FQ_PTR_W-1:0]   r_rp;
    logic [FQ_CNT_W-1:0]   r_cnt;
    logic [FQ_CNT_W-1:0]   n_cnt;
    logic                  do_push;
    logic                  do_pop;

    function automatic logic [FQ_PTR_W-1:0] ptr_inc(input logic [FQ_PTR_W-1:0] p);
        ptr_inc = (p == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : p + FQ_PTR_W'(1);
    endfunction

    assign o_full     = (r_cnt == FQ_CNT_W'(FQ_DEPTH));
    assign o_hs.valid = (r_cnt != '0);
    assign o_hs.take  = i_hs_take.take;
    assign o_frame    = r_mem[r_rp];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_hs_take.take && o_hs.valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + FQ_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - FQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (do_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_frame;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("frame pushed into a full queue");

    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hs_take.take |-> o_hs.valid)
        else $error("frame taken from an empty queue");

endmodule : imuf_fifo
`default_nettype wire

>>> src/imuf_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// imuf_back
// Gyro Y/Z moving average: stage A updates the histories and forms the
// full-width sums, stage B divides by the tap count and holds the result.
// ---------------------------------------------------------------------------
module imuf_back
    import imuf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_q_hs  i_q_hs,
    input  wire t_frame i_frame,
    output t_q_hs       o_q_take,
    output logic        o_empty,
    input  wire logic   i_pop,
    output t_result     o_result
);

    logic signed [15:0]      r_hist_y [HIST_D];
    logic signed [15:0]      r_hist_z [HIST_D];

    // stage A
    logic                    r_a_vld;
    t_frame                  r_a_frame;
    logic signed [SUM_W-1:0] r_a_sum_y;
    logic signed [SUM_W-1:0] r_a_sum_z;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_z;

    // stage B / output
    logic                    r_o_vld;
    t_result                 r_out;
    logic signed [15:0]      avg_y;
    logic signed [15:0]      avg_z;

    logic                    adv_a;
    logic                    adv_b;

    function automatic logic signed [15:0] div_taps(input logic signed [SUM_W-1:0] s);
        logic              neg;
        logic [SUM_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        logic [15:0]       q;
        neg  = s[SUM_W-1];
        mag  = neg ? SUM_W'(-s) : SUM_W'(s);
        prod = PROD_W'(mag) * PROD_W'(RECIP);
        q    = prod[RECIP_SHIFT +: 16];
        div_taps = neg ? 16'(~q + 16'd1) : q;
    endfunction

    assign adv_b         = r_a_vld && (!r_o_vld || i_pop);
    assign adv_a         = i_q_hs.valid && (!r_a_vld || adv_b);
    assign o_q_take.valid = i_q_hs.valid;
    assign o_q_take.take  = adv_a;

    always_comb begin
        sum_y = SUM_W'(i_frame.gyro_y);
        sum_z = SUM_W'(i_frame.gyro_z);
        for (int i = 0; i < HIST_D; i++) begin
            if (i < TAPS - 1) begin
                sum_y = sum_y + SUM_W'(r_hist_y[i]);
                sum_z = sum_z + SUM_W'(r_hist_z[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_D; i++) begin
                r_hist_y[i] <= '0;
                r_hist_z[i] <= '0;
            end
        end else if (adv_a && TAPS > 1) begin
            for (int i = HIST_D - 1; i > 0; i--) begin
                r_hist_y[i] <= r_hist_y[i-1];
                r_hist_z[i] <= r_hist_z[i-1];
            end
            r_hist_y[0] <= i_frame.gyro_y;
            r_hist_z[0] <= i_frame.gyro_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (adv_a) begin
                r_a_vld <= 1'b1;
            end else if (adv_b) begin
                r_a_vld <= 1'b0;
            end
            if (adv_b) begin
                r_o_vld <= 1'b1;
            end else if (i_pop) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    assign avg_y = div_taps(r_a_sum_y);
    assign avg_z = div_taps(r_a_sum_z);

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_a_frame <= i_frame;
            r_a_sum_y <= sum_y;
            r_a_sum_z <= sum_z;
        end
        if (adv_b) begin
            r_out.accel_x         <= r_a_frame.accel_x;
            r_out.accel_y         <= r_a_frame.accel_y;
            r_out.accel_z         <= r_a_frame.accel_z;
            r_out.temperature_raw <= r_a_frame.temperature_raw;
            r_out.gyro_x          <= r_a_frame.gyro_x;
            r_out.gyro_y_smoothed <= avg_y;
            r_out.gyro_z_smoothed <= avg_z;
        end
    end

    assign o_empty  = !r_o_vld;
    assign o_result = r_out;

    a_stage_a_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld && !adv_b |=> r_a_vld)
        else $error("stage A word dropped while stalled");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_b |=> r_o_vld)
        else $error("output register not loaded");

    a_hist_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_a && TAPS > 1 |=> r_hist_y[0] == $past(i_frame.gyro_y))
        else $error("gyro Y history not updated");

endmodule : imuf_back
`default_nettype wire

>>> src/imu_frame_unpack_gyro_smoother_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// imu_frame_unpack_gyro_smoother_core
// IMU burst unpacker with a moving average on the Y and Z gyro words.
//
// Input queue: push a byte with i_in_item while full is low. A set frame_start
// bit makes that byte byte 0 of a new burst; otherwise bytes fill positions
// 0..13 in order and wrap. One byte per cycle is taken while full is low.
// Output queue: when empty is low o_result holds the oldest frame; pop
// takes it. One result comes out per 14 bytes.
// The result of a burst passes, after its last byte is accepted, through the
// frame queue, the sum stage and the divide/output register, in that order.
// A two-entry frame queue plus the sum stage and the output register absorb
// output stalls; full rises only when the frame queue is full, i.e. once
// four frames are waiting behind a receiver that holds off pop.
// Reset (i_rst_n low, synchronous) zeros the byte position and the gyro
// histories and empties every stage; no clearing pass is needed.
// ---------------------------------------------------------------------------
module imu_frame_unpack_gyro_smoother_core
    import imuf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_item i_in_item,
    output logic          empty,
    input  wire logic     pop,
    output t_result       o_result
);

    logic   in_accept;
    logic   frame_push;
    t_frame front_frame;
    t_frame q_frame;
    t_q_hs  q_hs;
    t_q_hs  q_take;

    assign in_accept = push && !full;

    imuf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_item       (i_in_item),
        .o_frame_push (frame_push),
        .o_frame      (front_frame)
    );

    imuf_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (frame_push),
        .i_frame   (front_frame),
        .o_full    (full),
        .i_hs_take (q_take),
        .o_hs      (q_hs),
        .o_frame   (q_frame)
    );

    imuf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_hs   (q_hs),
        .i_frame  (q_frame),
        .o_q_take (q_take),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

endmodule : imu_frame_unpack_gyro_smoother_core
`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IMU frame unpacker with Y/Z gyro smoothing.
//
// Bytes go in through the push/full side and frames come back through the
// empty/pop side. A scoreboard class rebuilds every frame from the accepted
// bytes, runs its own moving average on the two gyro words and compares each
// popped frame field by field. Stimulus is a short directed burst, then
// three random phases with different idle mixes on both sides: mostly clean
// 14-byte bursts, runs of full-scale gyro words, cut-off bursts and noise.
// ---------------------------------------------------------------------------
module tb_top
    import imuf_pkg::*;
();

    localparam int AXIS_PITCH  = 0;
    localparam int AXIS_YAW    = 1;
    localparam int PHASE_BYTES = 590;
    localparam int HOLD_CYCLES = 400;

    // Rebuilds frames from accepted bytes and checks the popped ones.
    class imu_frame_board;
        t_result            expected_frames[$];
        logic [POS_W-1:0]   next_pos;
        logic [7:0]         held [HELD_BYTES];
        logic signed [15:0] rate_hist [2][HIST_D];
        int                 errors;
        int                 frames_checked;

        function new();
            next_pos       = '0;
            errors         = 0;
            frames_checked = 0;
            foreach (held[i]) held[i] = '0;
            foreach (rate_hist[a, i]) rate_hist[a][i] = '0;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        // full-width sum of sample plus history, truncating divide by TAPS
        function logic signed [15:0] smooth(int axis, logic signed [15:0] sample);
            int sum;
            sum = sample;
            for (int i = 0; i < TAPS - 1; i++) sum += rate_hist[axis][i];
            for (int i = TAPS - 2; i > 0; i--) rate_hist[axis][i] = rate_hist[axis][i-1];
            if (TAPS > 1) rate_hist[axis][0] = sample;
            return 16'(sum / TAPS);
        endfunction

        function void take_byte(t_in_item it);
            t_result r;
            if (it.frame_start) next_pos = '0;
            if (next_pos < HELD_BYTES) begin
                held[next_pos] = it.raw_byte;
                next_pos++;
            end else begin
                next_pos          = '0;
                r.accel_x         = {held[0], held[1]};
                r.accel_y         = {held[2], held[3]};
                r.accel_z         = {held[4], held[5]};
                r.temperature_raw = {held[6], held[7]};
                r.gyro_x          = {held[8], held[9]};
                r.gyro_y_smoothed = smooth(AXIS_PITCH, {held[10], held[11]});
                r.gyro_z_smoothed = smooth(AXIS_YAW, {held[12], it.raw_byte});
                expected_frames.push_back(r);
            end
        endfunction

        function string field_diff(string name, logic [15:0] got, logic [15:0] want);
            if (got === want) return "";
            return $sformatf(" %s=%h(exp %h)", name, got, want);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] frame %0d:%s", $time, frames_checked, msg);
        endtask

        task check_frame(t_result got);
            t_result want;
            string   diffs;
            if (expected_frames.size() == 0) begin
                report(" popped with no frame outstanding");
                return;
            end
            want = expected_frames.pop_front();
            frames_checked++;
            diffs = {field_diff("accel_x", got.accel_x, want.accel_x),
                     field_diff("accel_y", got.accel_y, want.accel_y),
                     field_diff("accel_z", got.accel_z, want.accel_z),
                     field_diff("temp", got.temperature_raw, want.temperature_raw),
                     field_diff("gyro_x", got.gyro_x, want.gyro_x),
                     field_diff("gyro_y", got.gyro_y_smoothed, want.gyro_y_smoothed),
                     field_diff("gyro_z", got.gyro_z_smoothed, want.gyro_z_smoothed)};
            if (diffs != "") report(diffs);
        endtask
    endclass

    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     push      = 1'b0;
    logic     pop       = 1'b0;
    t_in_item i_in_item = '0;
    logic     full;
    logic     empty;
    t_result  o_result;

    imu_frame_board board;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int bytes_pushed  = 0;
    int stall_cycles  = 0;
    int extreme_runs  = 0;
    int cut_bursts    = 0;

    imu_frame_unpack_gyro_smoother_core DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d frames outstanding", board.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random pop, plus a long hold-off when requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (pop && !empty) board.check_frame(o_result);
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0: return 8'h00;
                1: return 8'hFF;
                2: return 8'h80;
                default: return 8'h7F;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic start);
        t_in_item it;
        it.raw_byte    = b;
        it.frame_start = start;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (full) begin
            stall_cycles++;
            @(posedge i_clk);
        end
        board.take_byte(it);
        bytes_pushed++;
    endtask

    // first len bytes of fb; start flag on the first one if flagged
    task automatic send_bytes(input logic [7:0] fb [FRAME_BYTES], input bit flagged,
                              input int len);
        for (int i = 0; i < len; i++) send_byte(fb[i], flagged && (i == 0));
    endtask

    task automatic fill_random(output logic [7:0] fb [FRAME_BYTES]);
        foreach (fb[i]) fb[i] = rand_byte();
    endtask

    // six bursts with full-scale gyro words so the sum reaches its range
    task automatic send_extreme_run();
        logic [7:0] fb [FRAME_BYTES];
        bit         y_neg;
        bit         z_neg;
        y_neg = 1'($urandom_range(1));
        z_neg = 1'($urandom_range(1));
        extreme_runs++;
        repeat (6) begin
            fill_random(fb);
            {fb[10], fb[11]} = y_neg ? 16'h8000 : 16'h7FFF;
            {fb[12], fb[13]} = z_neg ? 16'h8000 : 16'h7FFF;
            send_bytes(fb, 1'b1, FRAME_BYTES);
        end
    endtask

    task automatic send_random_chunk();
        logic [7:0] fb [FRAME_BYTES];
        int         pick;
        pick = $urandom_range(99);
        fill_random(fb);
        if (pick < 70) begin
            // clean burst; some rely on the position wrap instead of the flag
            send_bytes(fb, $urandom_range(3) != 0, FRAME_BYTES);
        end else if (pick < 80) begin
            send_extreme_run();
        end else if (pick < 90) begin
            // cut-off burst, then a fresh flagged one restarts the position
            cut_bursts++;
            send_bytes(fb, 1'b1, $urandom_range(1, HELD_BYTES));
            fill_random(fb);
            send_bytes(fb, 1'b1, FRAME_BYTES);
        end else begin
            repeat ($urandom_range(1, 20))
                send_byte(rand_byte(), $urandom_range(3) == 0);
        end
    endtask

    task automatic wait_all_popped();
        push <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input int s_idle, input int r_idle, input bit with_hold);
        int phase_end;
        bit hold_done;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        phase_end     = bytes_pushed + PHASE_BYTES;
        hold_done     = 1'b0;
        while (bytes_pushed < phase_end) begin
            // receiver stops popping while bytes keep coming: full must rise
            if (with_hold && !hold_done && bytes_pushed >= phase_end - PHASE_BYTES / 2) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            send_random_chunk();
        end
    endtask

    initial begin
        logic [7:0] fb [FRAME_BYTES];
        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // min, max and -1 words; gyro words at both ends during filter startup
        fb = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
               8'h00, 8'h01, 8'h80, 8'h00, 8'h7F, 8'hFF};
        send_bytes(fb, 1'b1, FRAME_BYTES);
        // wrapped position, then a start flag drops the partial burst
        fb = '{8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_bytes(fb, 1'b0, 3);
        fb = '{8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h01, 8'h80, 8'hFE, 8'h7F,
               8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_bytes(fb, 1'b1, 8);

        run_phase(19, 51, 1'b1);
        wait_all_popped();
        run_phase(51, 19, 1'b0);
        wait_all_popped();
        run_phase(0, 0, 1'b1);

        wait_all_popped();
        repeat (10) @(posedge i_clk);
        $display("Run: %0d bytes pushed, %0d frames compared, %0d input stall cycles",
                 bytes_pushed, board.frames_checked, stall_cycles);
        $display("     %0d full-scale gyro runs, %0d cut-off bursts, %0d mismatches",
                 extreme_runs, cut_bursts, board.errors);
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule : tb_top
`default_nettype wire
